FILE: hw/rtl/kprc_pkg.sv
`timescale 1ns / 1ps

package kprc_pkg;

    localparam int unsigned CHAR_W = 7;
    localparam int unsigned SEED_W = 17;
    localparam int unsigned PROD_W = 24;
    localparam int unsigned CFG_W  = 17;

    localparam logic [6:0]  MULT     = 7'd75;
    localparam logic [15:0] LOW_MASK = 16'hFFFF;
    localparam logic [17:0] MODULUS  = 18'd65537;
    localparam logic [6:0]  BASE     = 7'd32;
    localparam logic [7:0]  SPAN     = 8'd96;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [SEED_W-1:0] t_seed;

    typedef enum logic [0:0] {
        CFG_MODE = 1'b0,
        CFG_KEY  = 1'b1
    } t_cfg_idx;

    // One generator step: s*75 mod 65537, low half minus high half, wrap if negative.
    function automatic t_seed gen_step(input t_seed s);
        logic [PROD_W-1:0] prod;
        logic [15:0]       lo;
        logic [7:0]        hi;
        logic [17:0]       wide;
        prod = PROD_W'(s) * PROD_W'(MULT);
        lo   = prod[15:0] & LOW_MASK;
        hi   = prod[23:16];
        if (lo >= 16'(hi)) begin
            wide = 18'(lo) - 18'(hi);
        end else begin
            wide = 18'(lo) + MODULUS - 18'(hi);
        end
        return wide[SEED_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/keystream_printable_rotate_cipher.sv
`timescale 1ns / 1ps

// Keystream rotate cipher for seven-bit characters.
// Input channel (i_in_valid / o_in_ready) carries one character request with a
// start-of-message flag; the flag reloads the generator seed from the key
// register before the step. Every request advances the multiplicative
// generator (seed*75 mod 65537) and yields exactly one output character on
// the output channel (o_out_valid / i_out_ready).
// Characters 32..127 rotate within that range by r mod 96, forward when mode
// is 0 and backward when mode is 1; characters below 32 pass unchanged.
// Pipeline: the seed step goes into the stage register when a request is
// accepted, and the rotation goes from there into the output register, which
// drives o_out_valid; a receiver stall can hold both registers.
// Throughput: one request per cycle while the receiver does not stall; the seed feedback
// loop is a constant multiply and fold with no register inside it.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0 mode, 1 key) at the clock edge; write only while the pipe is empty.
// Reset (synchronous, active low): mode 0, key 1, seed 1, pipeline empty.
// Receiver stall: the output register holds, the stage register holds behind
// it, and o_in_ready drops once both are full; no request is lost.
module keystream_printable_rotate_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  kprc_pkg::t_char               i_data_char,
    input  logic                          i_start_of_message,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output kprc_pkg::t_char               o_out_char,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [kprc_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import kprc_pkg::*;

    logic  r_mode;
    t_seed r_key;
    t_seed r_seed;

    logic  r_s1_vld;
    t_char r_s1_char;
    t_seed r_s1_rnd;

    logic  r_out_vld;
    t_char r_out_char;

    logic  out_adv;
    logic  in_acc;
    t_seed n_seed;
    t_char n_out_char;

    // Output register frees when empty or taken; stage 1 moves whenever it does.
    assign out_adv    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || out_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Step from the key on message start, else from the running seed.
    assign n_seed = gen_step(i_start_of_message ? r_key : r_seed);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_key  <= t_seed'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE: r_mode <= i_cfg_wdata[0];
                CFG_KEY:  r_key  <= i_cfg_wdata[SEED_W-1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // Generator state: advance once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= t_seed'(1);
        end else if (in_acc) begin
            r_seed <= n_seed;
        end
    end

    // Stage 1: character and generator value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_char <= i_data_char;
            r_s1_rnd  <= n_seed;
        end
    end

    kprc_rotate u_rotate (
        .i_char    (r_s1_char),
        .i_rnd     (r_s1_rnd),
        .i_decrypt (r_mode),
        .o_char    (n_out_char)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out_char <= n_out_char;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_char  = r_out_char;

`ifndef ASSERT_OFF
    // Generator value after a step is always folded into 0..65536.
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_s1_rnd <= t_seed'(65536)))
        else $error("generator value out of range");

    // Seed moves only when a request is accepted.
    a_seed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_seed))
        else $error("seed changed without a request");

    // A stalled output keeps the stage-1 request parked and unchanged.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_out_ready)
            |=> (r_s1_vld && $stable(r_s1_char) && $stable(r_s1_rnd)))
        else $error("stage 1 request lost under stall");
`endif

endmodule

FILE: hw/rtl/kprc_rotate.sv
`timescale 1ns / 1ps

module kprc_rotate (
    input  kprc_pkg::t_char i_char,
    input  kprc_pkg::t_seed i_rnd,
    input  logic            i_decrypt,
    output kprc_pkg::t_char o_char
);
    import kprc_pkg::*;

    logic [4:0] dsum;
    logic [4:0] m3;
    logic [6:0] k;
    logic [6:0] off;
    logic [7:0] acc;
    logic [7:0] wrapped;

    // rnd mod 96 = ((rnd >> 5) mod 3) * 32 + rnd[4:0]
    // mod 3 of the upper bits: sum base-4 digits, then fold down
    always_comb begin
        dsum = 5'(i_rnd[6:5]) + 5'(i_rnd[8:7]) + 5'(i_rnd[10:9])
             + 5'(i_rnd[12:11]) + 5'(i_rnd[14:13]) + 5'(i_rnd[16:15]);
        m3 = dsum;
        if (m3 >= 5'd12) m3 = m3 - 5'd12;
        if (m3 >= 5'd6)  m3 = m3 - 5'd6;
        if (m3 >= 5'd3)  m3 = m3 - 5'd3;
        k = {m3[1:0], i_rnd[4:0]};
    end

    always_comb begin
        off = i_char - BASE;
        if (i_decrypt) begin
            acc = 8'(off) + (SPAN - 8'(k));
        end else begin
            acc = 8'(off) + 8'(k);
        end
        wrapped = (acc >= SPAN) ? (acc - SPAN) : acc;
        if (i_char < BASE) begin
            o_char = i_char;
        end else begin
            o_char = wrapped[6:0] + BASE;
        end
    end

endmodule

FILE: test/keystream_printable_rotate_cipher_tb.sv
`timescale 1ns / 1ps

module keystream_printable_rotate_cipher_tb;

    import kprc_pkg::*;

    localparam int unsigned GEN_MULT    = 75;
    localparam int unsigned GEN_MOD     = 65537;
    localparam int unsigned PRINT_BASE  = 32;
    localparam int unsigned PRINT_SPAN  = 96;
    localparam int          SETTLE_CYC  = 4;
    localparam int          PHASE_COUNT = 8;
    localparam int          PHASE_LEN   = 60;
    localparam int          DIR_ROWS    = 19;

    // One directed request, optionally preceded by a write of both registers.
    // When typed is set, typed_out is the result read straight off the spec.
    typedef struct {
        logic        set_cfg;
        logic        cfg_mode;
        logic [16:0] cfg_key;
        t_char       ch;
        logic        som;
        logic        typed;
        t_char       typed_out;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_char       data_char = '0;
    logic        start_flag = 1'b0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_char       o_out_char;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_MODE;
    logic [16:0] cfg_wdata = '0;

    // Cipher state as the testbench sees it.
    logic        pred_mode = 1'b0;
    t_seed       pred_key = t_seed'(1);
    t_seed       pred_seed = t_seed'(1);

    t_char       expected_chars[$];
    t_char       want_char;
    t_dir_row    dir_rows[DIR_ROWS];

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          starts_sent = 0;
    int          results_seen = 0;
    int          end_wait = 0;

    always #4 i_clk = ~i_clk;

    keystream_printable_rotate_cipher u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_char        (data_char),
        .i_start_of_message (start_flag),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_out_char         (o_out_char),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata)
    );

    // Lehmer step: seed*75 mod 65537, folded as low half minus high half.
    function automatic t_seed lehmer_next(input t_seed s);
        logic [23:0] product;
        logic [15:0] low_half;
        logic [7:0]  high_half;
        product   = 24'(s) * 24'(GEN_MULT);
        low_half  = product[15:0];
        high_half = product[23:16];
        if (low_half >= 16'(high_half)) begin
            return t_seed'(low_half - 16'(high_half));
        end
        // Negative difference: add the modulus back.
        return t_seed'(17'(low_half) + 17'(GEN_MOD) - 17'(high_half));
    endfunction

    // Rotate within the printable band; control characters pass through.
    function automatic t_char band_rotate(input t_char c, input t_seed r, input logic dec);
        int unsigned shift_amt;
        int unsigned pos;
        if (c < PRINT_BASE) begin
            return c;
        end
        shift_amt = r % PRINT_SPAN;
        pos       = c - PRINT_BASE;
        if (dec) begin
            pos = (pos + PRINT_SPAN - shift_amt) % PRINT_SPAN;
        end else begin
            pos = (pos + shift_amt) % PRINT_SPAN;
        end
        return t_char'(pos + PRINT_BASE);
    endfunction

    // Advance the keystream for one accepted request and return its cipher char.
    function automatic t_char cipher_char(input t_char c, input logic som);
        if (som) begin
            pred_seed = pred_key;
        end
        pred_seed = lehmer_next(pred_seed);
        return band_rotate(c, pred_seed, pred_mode);
    endfunction

    function automatic t_char pick_char();
        int roll;
        roll = $urandom_range(15);
        if (roll < 3) begin
            return t_char'($urandom_range(31));
        end
        if (roll == 3) begin
            return t_char'(127);
        end
        if (roll == 4) begin
            return t_char'(PRINT_BASE);
        end
        return t_char'($urandom_range(127, PRINT_BASE));
    endfunction

    task automatic log_mismatch(input string what, input t_char exp_c, input t_char got_c);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch (%s): expected %0d, got %0d", $realtime, what, exp_c,
                     got_c);
        end
    endtask

    // Present one request; hold valid and payload until the block takes it.
    task automatic send_request(input t_char c, input logic som, input logic typed,
                                input t_char typed_out);
        t_char predicted;
        if ($urandom_range(99) < src_idle_pct) begin
            repeat ($urandom_range(1, 4)) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid   <= 1'b1;
        data_char  <= c;
        start_flag <= som;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = cipher_char(c, som);
        expected_chars.push_back(typed ? typed_out : predicted);
        requests_sent++;
        if (som) begin
            starts_sent++;
        end
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_pipe(input int settle);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write mode then key while the pipe is empty.
    task automatic write_config(input logic mode_v, input logic [16:0] key_v);
        drain_pipe(SETTLE_CYC);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_wdata <= 17'(mode_v);
        @(posedge i_clk);
        pred_mode = mode_v;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY;
        cfg_wdata <= key_v;
        @(posedge i_clk);
        pred_key = t_seed'(key_v);
        cfg_we   <= 1'b0;
    endtask

    // Receiver: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_chars.size() == 0) begin
                log_mismatch("no request outstanding", '0, o_out_char);
            end else begin
                want_char = expected_chars.pop_front();
                if (o_out_char !== want_char) begin
                    log_mismatch("out_char", want_char, o_out_char);
                end
            end
        end
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [16:0] phase_key;
        int          idle_mode;

        // After reset the seed is 1, so the first step gives r = 75.
        // Key 0 freezes the generator at 0: characters come out unchanged.
        // Key 65537 folds to 0 on the first step and then sticks there.
        dir_rows = '{
            '{1'b0, 1'b0, 17'd0,      7'd32,  1'b0, 1'b1, 7'd107},
            '{1'b0, 1'b0, 17'd0,      7'd0,   1'b0, 1'b1, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd127, 1'b0, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd31,  1'b1, 1'b1, 7'd31},
            '{1'b0, 1'b0, 17'd0,      7'd127, 1'b0, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd65,  1'b1, 1'b0, 7'd0},
            '{1'b1, 1'b1, 17'd1,      7'd107, 1'b1, 1'b1, 7'd32},
            '{1'b0, 1'b0, 17'd0,      7'd127, 1'b0, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd32,  1'b0, 1'b0, 7'd0},
            '{1'b1, 1'b0, 17'd0,      7'd127, 1'b1, 1'b1, 7'd127},
            '{1'b0, 1'b0, 17'd0,      7'd32,  1'b0, 1'b1, 7'd32},
            '{1'b0, 1'b0, 17'd0,      7'd85,  1'b0, 1'b1, 7'd85},
            '{1'b1, 1'b0, 17'd65536,  7'd127, 1'b1, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd64,  1'b0, 1'b0, 7'd0},
            '{1'b1, 1'b1, 17'd131071, 7'd127, 1'b1, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd96,  1'b0, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd33,  1'b0, 1'b0, 7'd0},
            '{1'b1, 1'b0, 17'd65537,  7'd100, 1'b1, 1'b0, 7'd0},
            '{1'b0, 1'b0, 17'd0,      7'd100, 1'b0, 1'b0, 7'd0}
        };

        // Hold reset, then release it for good.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: no idling, walk the rows in order.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg) begin
                write_config(dir_rows[i].cfg_mode, dir_rows[i].cfg_key);
            end
            send_request(dir_rows[i].ch, dir_rows[i].som, dir_rows[i].typed,
                         dir_rows[i].typed_out);
        end

        // Random part: each phase sets new registers and an idling pattern.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    phase_key = 17'd1;
                end
                1: begin
                    phase_key = 17'd65536;
                end
                2: begin
                    phase_key = 17'd131071;
                end
                3: begin
                    phase_key = 17'd0;
                end
                7: begin
                    phase_key = 17'($urandom_range(131071, 65537));
                end
                default: begin
                    phase_key = 17'($urandom_range(65536, 1));
                end
            endcase
            write_config(p[0], phase_key);

            idle_mode = p % 4;
            case (idle_mode)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 56;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 56;
                end
                default: begin
                    src_idle_pct   = 20;
                    sink_stall_pct = 20;
                end
            endcase

            for (int n = 0; n < PHASE_LEN; n++) begin
                // Pause the sender mid-phase until the pipe runs dry.
                if (n == PHASE_LEN / 2) begin
                    drain_pipe(0);
                end
                // Open each phase with a fresh message; restart now and then.
                send_request(pick_char(), (n == 0) || ($urandom_range(19) == 0), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (expected_chars.size() != 0 && end_wait < 10000) begin
            @(posedge i_clk);
            end_wait++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            mismatch_count += expected_chars.size();
            $display("%0d results never arrived", expected_chars.size());
        end

        $display("Sent %0d characters (%0d message starts), checked %0d results, %0d bad.",
                 requests_sent, starts_sent, results_seen, mismatch_count);
        $display("Covered both directions, keys 0, 1, 65536, 65537, 131071 and random keys.");
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
